/* hdl/conv2d_3x3_replicate_border_macros.svh */
// Assertion macros for the 3x3 convolution block.
// Each use needs clk and rst_n in scope.
`ifndef CONV2D_3X3_REPLICATE_BORDER_MACROS_SVH
`define CONV2D_3X3_REPLICATE_BORDER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define C3R_ASSERT_SAME(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("check failed: same-cycle implication");
// Next-cycle implication.
`define C3R_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("check failed: next-cycle implication");
`else
`define C3R_ASSERT_SAME(lbl, a, b)
`define C3R_ASSERT_NEXT(lbl, a, b)
`endif

`endif

/* hdl/c3r_pkg.sv */
`default_nettype none
package c3r_pkg;

  // Geometry and field widths
  localparam int MaxWidth  = 1024;
  localparam int AddrW     = $clog2(MaxWidth);
  localparam int PixW      = 16;
  localparam int ColW      = 3 * PixW;
  localparam int ValW      = 32;
  localparam int WidthCfgW = 11;
  localparam int HeightW   = 16;
  localparam int KernW     = 48;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 48;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKernelTop   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKernelMid   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKernelBot   = 3'd4;

  // Input item kinds
  localparam logic CmdPixel = 1'b0;
  localparam logic CmdFlush = 1'b1;

  typedef logic [ColW-1:0]         col_t;   // top pixel in low bits
  typedef col_t [2:0]              win_t;   // element 0 is the leftmost column
  typedef logic [2:0][KernW-1:0]   kern_t;  // element 0 is the top kernel row

  typedef struct packed {
    win_t win;
    logic last;
  } job_t;

  typedef struct packed {
    logic [AddrW-1:0]   wm1;      // effective width minus one
    logic [HeightW-1:0] h;        // effective height
    logic               restart;  // geometry write this cycle
  } geom_t;

  typedef struct packed {
    logic s1_valid;
    logic row_end_first;  // first half of a row-end item
    logic s1_stalled;     // result waiting on the multiply pipeline
  } stat_t;

  function automatic col_t col_pack(input logic [PixW-1:0] top,
                                    input logic [PixW-1:0] mid,
                                    input logic [PixW-1:0] bot);
    return {bot, mid, top};
  endfunction

endpackage
`default_nettype wire

/* hdl/c3r_ram.sv */
`default_nettype none
module c3r_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hdl/c3r_front.sv */
`default_nettype none
module c3r_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [c3r_pkg::PixW-1:0]    in_tdata,
  input  wire logic                        in_tuser,
  input  wire c3r_pkg::geom_t              geom,
  output logic                             job_valid,
  input  wire logic                        job_ready,
  output c3r_pkg::job_t                    job,
  output c3r_pkg::stat_t                   stat
);
  import c3r_pkg::*;

  // Position counters
  logic [AddrW-1:0]   col_r, col_nxt;
  logic [HeightW-1:0] row_r, row_nxt;
  logic [AddrW-1:0]   flush_r, flush_nxt;

  // Column 0 of both lines, kept in flops for the first flush
  logic [PixW-1:0] above0_r, cur0_r;

  // Read stage
  logic             s1_valid_r, s1_phase_r, s1_flush_r, s1_row0_r;
  logic             s1_first_r, s1_second_r, s1_c0_r, s1_last_r;
  logic [AddrW-1:0] s1_addr_r;
  logic [PixW-1:0]  s1_pix_r;
  logic             s1_fwd_r;
  logic [PixW-1:0]  s1_fwd_above_r, s1_fwd_cur_r;

  win_t window_r, win_step;

  logic             in_flush, is_flush, acc, take, last_col, k_last;
  logic [AddrW-1:0] rd_addr;
  logic [PixW-1:0]  above_q, cur_q, above_d, cur_d;
  logic             emit_now, step, s1_done;
  logic             wr_en;
  logic [PixW-1:0]  wr_above;
  col_t             col_px, col_fl, col_0;
  win_t             base;

  // Decode the incoming item
  assign in_flush = row_r >= geom.h;
  assign is_flush = in_tuser == CmdFlush;
  assign acc      = in_tvalid && in_tready;
  assign take     = acc && (is_flush == in_flush);
  assign last_col = col_r == geom.wm1;
  assign k_last   = flush_r == geom.wm1;
  assign rd_addr  = is_flush ? (k_last ? geom.wm1 : flush_r + AddrW'(1)) : col_r;

  // Line memories
  c3r_ram #(.Width(PixW), .Depth(MaxWidth)) u_above (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr_r),
    .wdata (wr_above),
    .re    (take),
    .raddr (rd_addr),
    .rdata (above_q)
  );

  c3r_ram #(.Width(PixW), .Depth(MaxWidth)) u_cur (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr_r),
    .wdata (s1_pix_r),
    .re    (take),
    .raddr (rd_addr),
    .rdata (cur_q)
  );

  // Forward a write that raced the read of the same entry
  assign above_d = s1_fwd_r ? s1_fwd_above_r : above_q;
  assign cur_d   = s1_fwd_r ? s1_fwd_cur_r   : cur_q;

  // Stage handshake
  assign emit_now  = s1_phase_r ? 1'b1 : s1_first_r;
  assign job_valid = s1_valid_r && emit_now;
  assign step      = s1_valid_r && (!emit_now || job_ready);
  assign s1_done   = step && !(!s1_phase_r && s1_second_r);
  assign in_tready = !s1_valid_r || s1_done;

  // Line write-back
  assign wr_en    = step && !s1_phase_r && !s1_flush_r;
  assign wr_above = s1_row0_r ? s1_pix_r : cur_d;

  // Window update
  assign col_px = col_pack(above_d, cur_d, s1_pix_r);
  assign col_fl = col_pack(above_d, cur_d, cur_d);
  assign col_0  = col_pack(above0_r, cur0_r, cur0_r);

  always_comb begin
    base     = window_r;
    win_step = window_r;
    if (s1_phase_r) begin
      // Replicate the right edge
      win_step[0] = window_r[1];
      win_step[1] = window_r[2];
      win_step[2] = window_r[2];
    end else if (s1_flush_r) begin
      if (s1_c0_r) begin
        base[0] = col_0;
        base[1] = col_0;
        base[2] = col_0;
      end
      win_step[0] = base[1];
      win_step[1] = base[2];
      win_step[2] = col_fl;
    end else if (!s1_row0_r) begin
      if (s1_c0_r) begin
        win_step[0] = col_px;
        win_step[1] = col_px;
        win_step[2] = col_px;
      end else begin
        win_step[0] = window_r[1];
        win_step[1] = window_r[2];
        win_step[2] = col_px;
      end
    end
  end

  assign job.win  = win_step;
  assign job.last = !s1_phase_r && s1_flush_r && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (step) begin
      window_r <= win_step;
    end
  end

  // Stage valid and phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_phase_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= take;
      end
      if (s1_done) begin
        s1_phase_r <= 1'b0;
      end else if (step) begin
        s1_phase_r <= 1'b1;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (take) begin
      s1_flush_r     <= is_flush;
      s1_addr_r      <= rd_addr;
      s1_pix_r       <= in_tdata;
      s1_row0_r      <= !is_flush && (row_r == '0);
      s1_first_r     <= is_flush || ((row_r != '0) && (col_r != '0));
      s1_second_r    <= !is_flush && (row_r != '0) && last_col;
      s1_c0_r        <= is_flush ? (flush_r == '0) : (col_r == '0);
      s1_last_r      <= k_last;
      s1_fwd_r       <= wr_en && (s1_addr_r == rd_addr);
      s1_fwd_above_r <= wr_above;
      s1_fwd_cur_r   <= s1_pix_r;
    end
  end

  // Track column 0 of both lines
  always_ff @(posedge clk) begin
    if (take && !is_flush && (col_r == '0)) begin
      above0_r <= (row_r == '0) ? in_tdata : cur0_r;
      cur0_r   <= in_tdata;
    end
  end

  // Advance position counters
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    flush_nxt = flush_r;
    if (geom.restart) begin
      col_nxt   = '0;
      row_nxt   = '0;
      flush_nxt = '0;
    end else if (take) begin
      if (is_flush) begin
        if (k_last) begin
          col_nxt   = '0;
          row_nxt   = '0;
          flush_nxt = '0;
        end else begin
          flush_nxt = flush_r + AddrW'(1);
        end
      end else if (last_col) begin
        col_nxt = '0;
        row_nxt = row_r + HeightW'(1);
      end else begin
        col_nxt = col_r + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      flush_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      flush_r <= flush_nxt;
    end
  end

  assign stat.s1_valid      = s1_valid_r;
  assign stat.row_end_first = s1_valid_r && !s1_phase_r && s1_second_r;
  assign stat.s1_stalled    = job_valid && !job_ready;

endmodule
`default_nettype wire

/* hdl/c3r_mac.sv */
`default_nettype none
module c3r_mac (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      job_valid,
  output logic                           job_ready,
  input  wire c3r_pkg::job_t             job,
  input  wire c3r_pkg::kern_t            kern,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [c3r_pkg::ValW-1:0]       out_tdata,
  output logic                           out_tlast
);
  import c3r_pkg::*;

  logic                   p_valid_r, p_last_r;
  logic [2:0][2:0][ValW-1:0] prod_r, prod;
  logic                   r_valid_r, r_last_r;
  logic [2:0][ValW-1:0]   rsum_r, rsum;
  logic                   o_valid_r, o_last_r;
  logic [ValW-1:0]        o_data_r;
  logic                   ready_o, ready_r;

  // Each stage moves when it is empty or its successor moves
  assign ready_o   = !o_valid_r || out_tready;
  assign ready_r   = !r_valid_r || ready_o;
  assign job_ready = !p_valid_r || ready_r;

  // Nine products, one per tap
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[i][j] = ValW'($signed(kern[i][PixW*j +: PixW]) *
                           $signed(job.win[j][PixW*i +: PixW]));
      end
    end
  end

  // Row sums, wrapping
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i] = prod_r[i][0] + prod_r[i][1] + prod_r[i][2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      r_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (job_ready) begin
        p_valid_r <= job_valid;
      end
      if (ready_r) begin
        r_valid_r <= p_valid_r;
      end
      if (ready_o) begin
        o_valid_r <= r_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      prod_r   <= prod;
      p_last_r <= job.last;
    end
    if (ready_r && p_valid_r) begin
      rsum_r   <= rsum;
      r_last_r <= p_last_r;
    end
    if (ready_o && r_valid_r) begin
      o_data_r <= rsum_r[0] + rsum_r[1] + rsum_r[2];
      o_last_r <= r_last_r;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = o_data_r;
  assign out_tlast  = o_last_r;

endmodule
`default_nettype wire

/* hdl/conv2d_3x3_replicate_border.sv */
// 3x3 convolution over a raster pixel stream with replicated borders.
// in_*  : one item per transfer; tuser 0 carries a pixel in tdata, tuser 1
//         is a flush item. Send H rows of W pixels, then W flush items.
// out_* : one 32-bit wrapped sum per transfer in raster order; tlast marks
//         the frame's final output (the last flush).
// cfg_* : register writes (width, height, three kernel rows); always ready.
//         A width or height write restarts the frame. Write only when idle.
// A result passes the window stage, then the product, row-sum and output
// registers; the second result of a row end follows the first.
// Throughput: one item per cycle unless the output stalls; the last pixel
// of each row after the first holds the input for its second window, as
// the window stage hands one window per cycle to the multiply pipeline.
// Pixels of row 0 give no result. The line memories are read at the
// transfer; pixel items write them back as they step in the window stage.
// Reset: counters and window clear, registers take their defaults; the
// line memories are not cleared, row 0 writes every entry later read.
// Output stall: results hold; up to four items stay in flight
// before in_tready drops.
`default_nettype none
`include "conv2d_3x3_replicate_border_macros.svh"
module conv2d_3x3_replicate_border (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [c3r_pkg::PixW-1:0]       in_tdata,   // [15:0] pixel
  input  wire logic                           in_tuser,   // [0] cmd
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [c3r_pkg::ValW-1:0]            out_tdata,  // [31:0] value
  output logic                                out_tlast,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [c3r_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [c3r_pkg::CfgDataW-1:0]   cfg_data
);
  import c3r_pkg::*;

  logic [WidthCfgW-1:0] frame_width_r;
  logic [HeightW-1:0]   frame_height_r;
  kern_t                kern_r;
  geom_t                geom;
  job_t                 job;
  logic                 job_valid, job_ready;
  stat_t                stat;
  int unsigned          w_eff;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WidthCfgW'(1024);
      frame_height_r <= HeightW'(1024);
      kern_r         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegFrameWidth:  frame_width_r  <= cfg_data[WidthCfgW-1:0];
        RegFrameHeight: frame_height_r <= cfg_data[HeightW-1:0];
        RegKernelTop:   kern_r[0]      <= cfg_data[KernW-1:0];
        RegKernelMid:   kern_r[1]      <= cfg_data[KernW-1:0];
        RegKernelBot:   kern_r[2]      <= cfg_data[KernW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp geometry
  always_comb begin
    w_eff = (frame_width_r == '0) ? 1 : 32'(frame_width_r);
    if (w_eff > MaxWidth) begin
      w_eff = MaxWidth;
    end
    geom.wm1     = AddrW'(w_eff - 1);
    geom.h       = (frame_height_r == '0) ? HeightW'(1) : frame_height_r;
    geom.restart = cfg_valid && cfg_ready &&
                   ((cfg_index == RegFrameWidth) || (cfg_index == RegFrameHeight));
  end

  c3r_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .geom      (geom),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .stat      (stat)
  );

  c3r_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .job        (job),
    .kern       (kern_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // No new transfer while a row-end item still owes its second result
  `C3R_ASSERT_SAME(a_row_end_blocks_input, stat.row_end_first, !in_tready)
  // A result held back by the multiply pipeline keeps its item
  `C3R_ASSERT_NEXT(a_stalled_item_kept, stat.s1_stalled, stat.s1_valid)

endmodule
`default_nettype wire
